/* design/mcpd_pkg.sv */
// Shared types and constants for the multi-class priority deque unit.
// No dependencies; every other file of the block refers to this package.
package mcpd_pkg;

  localparam int ACTION_W = 2;
  localparam int QIDX_W   = 5;
  localparam int TAG_W    = 16;
  localparam int OCC_W    = 3;

  // Request action codes; any code with the high bit set serves the head.
  localparam logic [ACTION_W-1:0] ACT_REGULAR = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_URGENT  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SERVE   = 2'd2;

  typedef enum logic [1:0] {
    OUT_ADDED  = 2'd0,
    OUT_FULL   = 2'd1,
    OUT_SERVED = 2'd2,
    OUT_EMPTY  = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_MOVE,
    ST_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic reject;
    logic append;
    logic scan_start;
    logic scan_step;
    logic commit;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
    logic serve;
    logic urgent;
    logic empty;
    logic full;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

/* design/mcpd_req_if.sv */
// Request channel of the deque unit: valid/ready handshake and payload.
// Depends on mcpd_pkg for field widths.
interface mcpd_req_if;
  logic                          valid;
  logic                          ready;
  logic [mcpd_pkg::ACTION_W-1:0] action;
  logic [mcpd_pkg::QIDX_W-1:0]   queue_index;
  logic [mcpd_pkg::TAG_W-1:0]    entry_tag;

  modport source (output valid, action, queue_index, entry_tag, input ready);
  modport sink   (input valid, action, queue_index, entry_tag, output ready);
endinterface

/* design/mcpd_rsp_if.sv */
// Result channel of the deque unit: valid/ready handshake and payload.
// Depends on mcpd_pkg for field widths and the outcome type.
interface mcpd_rsp_if;
  logic                       valid;
  logic                       ready;
  mcpd_pkg::outcome_t         outcome;
  logic [mcpd_pkg::TAG_W-1:0] served_tag;
  logic                       served_urgent;
  logic [mcpd_pkg::OCC_W-1:0] occupancy;

  modport source (output valid, outcome, served_tag, served_urgent, occupancy,
                  input ready);
  modport sink   (input valid, outcome, served_tag, served_urgent, occupancy,
                  output ready);
endinterface

/* design/multi_class_priority_deque_unit.sv */
// Multi-class priority deque: NUM_QUEUES bounded queues of QUEUE_DEPTH entries,
// with tail append, urgent head insert and head serve, one result per request.
// Depends on mcpd_pkg, mcpd_req_if, mcpd_rsp_if, mcpd_controller, mcpd_datapath.
//
// One request is in work at a time. A rejected request or a regular append
// goes from decision straight to the result; a serve or an urgent insert first
// moves the queue's entries by one slot through the entry memory, one read and
// one write per cycle (a serve drops the head entry instead of moving it), then
// lands the last write and commits. The next request is taken while a
// finished result still waits in the output register; a result waits only
// when the previous one has not been taken. Queue counts clear at reset;
// entry slots need no clear.
module multi_class_priority_deque_unit #(
  parameter int NUM_QUEUES  = 32,
  parameter int QUEUE_DEPTH = 5,
  parameter int TAG_WIDTH   = 16
) (
  input logic        clk,
  input logic        rst,
  mcpd_req_if.sink   req,
  mcpd_rsp_if.source rsp
);

  mcpd_pkg::dp_cmd_t    cmd;
  mcpd_pkg::dp_status_t st;
  logic                 ctl_ready;

  assign req.ready = ctl_ready;

  mcpd_controller u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (ctl_ready),
    .st        (st),
    .cmd       (cmd)
  );

  mcpd_datapath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .action      (req.action),
    .queue_index (req.queue_index),
    .entry_tag   (req.entry_tag),
    .cmd         (cmd),
    .st          (st),
    .rsp         (rsp)
  );

endmodule

/* design/mcpd_datapath.sv */
// Datapath of the deque unit: request registers, queue counts, entry memory,
// shift pointers and the result register. Depends on mcpd_pkg, mcpd_rsp_if.
module mcpd_datapath #(
  parameter int NUM_QUEUES  = 32,
  parameter int QUEUE_DEPTH = 5,
  parameter int TAG_WIDTH   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mcpd_pkg::ACTION_W-1:0] action,
  input  logic [mcpd_pkg::QIDX_W-1:0]   queue_index,
  input  logic [mcpd_pkg::TAG_W-1:0]    entry_tag,
  input  mcpd_pkg::dp_cmd_t             cmd,
  output mcpd_pkg::dp_status_t          st,
  mcpd_rsp_if.source                    rsp
);

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW    = (TAG_WIDTH < mcpd_pkg::TAG_W) ? TAG_WIDTH : mcpd_pkg::TAG_W;

  // request registers
  logic                        req_serve;
  logic                        req_urgent;
  logic [mcpd_pkg::QIDX_W-1:0] req_q;
  logic [SW-1:0]               req_tag;

  logic [CW-1:0] counts [NUM_QUEUES];
  logic [SW:0]   mem [SLOTS];
  logic [SW:0]   rd_data;

  logic          bad;
  logic [QW-1:0] q_idx;
  logic [CW-1:0] cnt_cur;
  logic [AW-1:0] base;

  logic [CW-1:0] rd_ptr;
  logic [CW-1:0] rd_left;
  logic          pend;
  logic [CW-1:0] pend_src;
  logic [CW-1:0] dst_dn;
  logic [CW-1:0] dst_up;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [SW:0]   mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;

  mcpd_pkg::outcome_t res_outcome;
  logic [SW-1:0]      res_tag;
  logic               res_urg;
  logic [CW-1:0]      res_occ;

  logic out_free;

  assign bad     = (32'(req_q) >= NUM_QUEUES);
  assign q_idx   = bad ? '0 : QW'(req_q);
  assign cnt_cur = counts[q_idx];
  assign base    = AW'(32'(q_idx) * QUEUE_DEPTH);
  assign dst_dn  = pend_src - 1'b1;
  assign dst_up  = pend_src + 1'b1;
  assign out_free = !rsp.valid || rsp.ready;

  always_comb begin
    st.bad       = bad;
    st.serve     = req_serve;
    st.urgent    = req_urgent;
    st.empty     = (cnt_cur == '0);
    st.full      = (cnt_cur == CW'(QUEUE_DEPTH));
    st.scan_done = (rd_left == '0) && !pend;
    st.out_free  = out_free;
  end

  // capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_serve  <= 1'b0;
      req_urgent <= 1'b0;
      req_q      <= '0;
      req_tag    <= '0;
    end else if (cmd.capture) begin
      req_serve  <= (action >= mcpd_pkg::ACT_SERVE);
      req_urgent <= (action == mcpd_pkg::ACT_URGENT);
      req_q      <= queue_index;
      req_tag    <= entry_tag[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        counts[i] <= '0;
      end
    end else if (cmd.append || (cmd.commit && req_urgent)) begin
      counts[q_idx] <= cnt_cur + 1'b1;
    end else if (cmd.commit) begin
      counts[q_idx] <= cnt_cur - 1'b1;
    end
  end

  // entry memory port selection; the urgent mark rides in the top bit
  assign mem_re = cmd.scan_step && (rd_left != '0);
  assign mem_ra = base + AW'(rd_ptr);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = base + AW'(cnt_cur);
    mem_wd = {1'b0, req_tag};
    if (cmd.append) begin
      mem_we = 1'b1;
    end else if (cmd.commit && req_urgent) begin
      mem_we = 1'b1;
      mem_wa = base;
      mem_wd = {1'b1, req_tag};
    end else if (cmd.scan_step && pend) begin
      mem_wd = rd_data;
      if (req_serve) begin
        // the head slot leaves the queue instead of moving
        mem_we = (pend_src != '0);
        mem_wa = base + AW'(dst_dn);
      end else begin
        mem_we = 1'b1;
        mem_wa = base + AW'(dst_up);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data <= mem[mem_ra];
    end
  end

  // shift sequencing: serve walks up from the head, urgent walks down to it
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_left <= '0;
      pend    <= 1'b0;
    end else if (cmd.scan_start) begin
      rd_ptr  <= req_serve ? '0 : cnt_cur - 1'b1;
      rd_left <= cnt_cur;
      pend    <= 1'b0;
    end else if (cmd.scan_step) begin
      pend <= mem_re;
      if (mem_re) begin
        rd_ptr   <= req_serve ? rd_ptr + 1'b1 : rd_ptr - 1'b1;
        rd_left  <= rd_left - 1'b1;
        pend_src <= rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reject) begin
      res_outcome <= req_serve ? mcpd_pkg::OUT_EMPTY : mcpd_pkg::OUT_FULL;
      res_tag     <= '0;
      res_urg     <= 1'b0;
      res_occ     <= bad ? '0 : cnt_cur;
    end else if (cmd.append) begin
      res_outcome <= mcpd_pkg::OUT_ADDED;
      res_tag     <= '0;
      res_urg     <= 1'b0;
      res_occ     <= cnt_cur + 1'b1;
    end else if (cmd.scan_start) begin
      res_tag <= '0;
      res_urg <= 1'b0;
    end else if (cmd.commit) begin
      res_outcome <= req_serve ? mcpd_pkg::OUT_SERVED : mcpd_pkg::OUT_ADDED;
      res_occ     <= req_serve ? cnt_cur - 1'b1 : cnt_cur + 1'b1;
    end else if (cmd.scan_step && pend && req_serve && (pend_src == '0)) begin
      res_tag <= rd_data[SW-1:0];
      res_urg <= rd_data[SW];
    end
  end

  // output register; holds until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      rsp.outcome       <= res_outcome;
      rsp.served_tag    <= mcpd_pkg::TAG_W'(res_tag);
      rsp.served_urgent <= res_urg;
      rsp.occupancy     <= mcpd_pkg::OCC_W'(res_occ);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_cur <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> !bad && !st.full && !req_serve)
    else $error("append issued without room");

  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !pend && (rd_left == '0))
    else $error("commit with shift still in flight");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result overwrites one not yet taken");

endmodule

/* design/mcpd_controller.sv */
// Sequencer of the deque unit: accepts a request, decides the action and
// steps the datapath through shifts and result hand-off. Depends on mcpd_pkg.
module mcpd_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  mcpd_pkg::dp_status_t st,
  output mcpd_pkg::dp_cmd_t    cmd
);

  mcpd_pkg::ctl_state_t state;
  mcpd_pkg::ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcpd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = (state == mcpd_pkg::ST_IDLE) && !rst;
    unique case (state)
      mcpd_pkg::ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = mcpd_pkg::ST_DECIDE;
        end
      end
      mcpd_pkg::ST_DECIDE: begin
        if (st.bad || (st.serve && st.empty) || (!st.serve && st.full)) begin
          cmd.reject = 1'b1;
          state_next = mcpd_pkg::ST_EMIT;
        end else if (!st.serve && !st.urgent) begin
          cmd.append = 1'b1;
          state_next = mcpd_pkg::ST_EMIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = mcpd_pkg::ST_MOVE;
        end
      end
      mcpd_pkg::ST_MOVE: begin
        cmd.scan_step = 1'b1;
        if (st.scan_done) begin
          cmd.commit = 1'b1;
          state_next = mcpd_pkg::ST_EMIT;
        end
      end
      mcpd_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = mcpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mcpd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
